// ----- sv/slte_pkg.sv -----
package slte_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_SEARCH = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_DUMP   = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      entry_valid;
    logic                      last;
    logic [CNT_W-1:0]          count;
  } out_word_t;

  typedef struct packed {
    cell_op_e op;
    logic     occ;
    logic     tail;
  } cell_ctl_t;

endpackage

// ----- sv/sorted_list_table_engine.sv -----
// channel | signals                            | word
// in      | in_valid_i  in_ready_o  in_data_i   | in_word_t  {kind, value}
// out     | out_valid_o out_ready_i out_data_o  | out_word_t {status, entry_value,
//         |                                     |   entry_valid, last, count}
// Insert, search, delete, clear, unused kinds and a dump of an empty table: one result word each.
// Dump: one result word per stored entry, one per cycle while the output is not stalled, by rotating the cell chain.
// The next word is taken once the previous operation has handed off its last result.
// Output register stalls on out_ready_i low; the chain holds meanwhile.
// Reset clears the count and control only; cell contents need no reset.
module sorted_list_table_engine
  import slte_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   dump_left_q, dump_left_d;
  out_word_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free, accept, found;
  cell_op_e          op;
  logic [CntW+CNT_W-1:0] count_wide;

  logic signed [VALUE_W-1:0] entry   [DEPTH];
  logic signed [VALUE_W-1:0] left_e  [DEPTH];
  logic signed [VALUE_W-1:0] right_e [DEPTH];
  logic                      left_lt [DEPTH];
  logic [DEPTH-1:0]          lt_v, eq_v;
  cell_ctl_t                 ctl     [DEPTH];

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign found      = |eq_v;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_e[i]  = '0;
      assign left_lt[i] = 1'b1;
    end else begin : g_mid
      assign left_e[i]  = entry[i-1];
      assign left_lt[i] = lt_v[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_e[i] = '0;
    end else begin : g_inner
      assign right_e[i] = entry[i+1];
    end

    assign ctl[i].op   = op;
    assign ctl[i].occ  = CntW'(i) < count_q;
    assign ctl[i].tail = CntW'(i) == (count_q - 1'b1);

    slte_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[i]),
      .value_i      (in_data_i.value),
      .left_entry_i (left_e[i]),
      .left_lt_i    (left_lt[i]),
      .right_entry_i(right_e[i]),
      .head_entry_i (entry[0]),
      .entry_o      (entry[i]),
      .lt_o         (lt_v[i]),
      .eq_o         (eq_v[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.kind == KIND_DUMP) && (count_q != '0)) begin
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (slot_free && (dump_left_q == CntW'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op          = CELL_HOLD;
    count_d     = count_q;
    dump_left_d = dump_left_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    count_wide  = '0;
    if (accept) begin
      out_valid_d       = 1'b1;
      out_d.status      = STAT_OK;
      out_d.entry_value = '0;
      out_d.entry_valid = 1'b0;
      out_d.last        = 1'b1;
      case (in_data_i.kind)
        KIND_INSERT: begin
          if (count_q == CntW'(DEPTH)) begin
            out_d.status = STAT_FULL;
          end else begin
            op      = CELL_INS;
            count_d = count_q + 1'b1;
          end
        end
        KIND_SEARCH, KIND_DELETE: begin
          if (count_q == '0) begin
            out_d.status = STAT_EMPTY;
          end else if (!found) begin
            out_d.status = STAT_MISS;
          end else if (in_data_i.kind == KIND_DELETE) begin
            op      = CELL_DEL;
            count_d = count_q - 1'b1;
          end
        end
        KIND_CLEAR: begin
          if (count_q == '0) begin
            out_d.status = STAT_EMPTY;
          end else begin
            count_d = '0;
          end
        end
        KIND_DUMP: begin
          if (count_q == '0) begin
            out_d.status = STAT_EMPTY;
          end else begin
            out_valid_d = 1'b0;
            dump_left_d = count_q;
          end
        end
        default: out_d.status = STAT_OK;
      endcase
    end else if ((state_q == ST_DUMP) && slot_free) begin
      op                = CELL_ROT;
      out_valid_d       = 1'b1;
      out_d.status      = STAT_OK;
      out_d.entry_value = entry[0];
      out_d.entry_valid = 1'b1;
      out_d.last        = dump_left_q == CntW'(1);
      dump_left_d       = dump_left_q - 1'b1;
    end
    count_wide  = {{CNT_W{1'b0}}, count_d};
    out_d.count = count_wide[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dump_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_left_q <= dump_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/slte_cell.sv -----
module slte_cell
  import slte_pkg::*;
(
  input  logic                      clk_i,
  input  cell_ctl_t                 ctl_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic signed [VALUE_W-1:0] left_entry_i,
  input  logic                      left_lt_i,
  input  logic signed [VALUE_W-1:0] right_entry_i,
  input  logic signed [VALUE_W-1:0] head_entry_i,
  output logic signed [VALUE_W-1:0] entry_o,
  output logic                      lt_o,
  output logic                      eq_o
);

  logic signed [VALUE_W-1:0] entry_q, entry_d;

  assign lt_o    = ctl_i.occ && (entry_q < value_i);
  assign eq_o    = ctl_i.occ && (entry_q == value_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      CELL_INS: begin
        if (!lt_o) begin
          entry_d = left_lt_i ? value_i : left_entry_i;
        end
      end
      CELL_DEL: begin
        if (!lt_o) begin
          entry_d = right_entry_i;
        end
      end
      CELL_ROT: begin
        entry_d = ctl_i.tail ? head_entry_i : right_entry_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- bench/sorted_table_checker.sv -----
module sorted_table_checker
  import slte_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic signed [VALUE_W-1:0] stored_vals[$];
  out_word_t                 expected_words[$];

  function automatic void expect_word(status_e st, logic signed [VALUE_W-1:0] val,
                                      logic vld, logic lst);
    out_word_t w;
    w.status      = st;
    w.entry_value = val;
    w.entry_valid = vld;
    w.last        = lst;
    w.count       = CNT_W'(stored_vals.size());
    expected_words.push_back(w);
  endfunction

  function automatic void apply_word(in_word_t w);
    int pos;
    pos = 0;
    case (w.kind)
      KIND_INSERT: begin
        if (stored_vals.size() >= DEPTH) begin
          expect_word(STAT_FULL, '0, 1'b0, 1'b1);
        end else begin
          while (pos < stored_vals.size() && stored_vals[pos] < $signed(w.value)) pos++;
          stored_vals.insert(pos, w.value);
          expect_word(STAT_OK, '0, 1'b0, 1'b1);
        end
      end
      KIND_SEARCH, KIND_DELETE: begin
        if (stored_vals.size() == 0) begin
          expect_word(STAT_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          while (pos < stored_vals.size() && stored_vals[pos] != $signed(w.value)) pos++;
          if (pos >= stored_vals.size()) begin
            expect_word(STAT_MISS, '0, 1'b0, 1'b1);
          end else begin
            if (w.kind == KIND_DELETE) stored_vals.delete(pos);
            expect_word(STAT_OK, '0, 1'b0, 1'b1);
          end
        end
      end
      KIND_CLEAR: begin
        if (stored_vals.size() == 0) begin
          expect_word(STAT_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          stored_vals.delete();
          expect_word(STAT_OK, '0, 1'b0, 1'b1);
        end
      end
      KIND_DUMP: begin
        if (stored_vals.size() == 0) begin
          expect_word(STAT_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          foreach (stored_vals[i])
            expect_word(STAT_OK, stored_vals[i], 1'b1, i == stored_vals.size() - 1);
        end
      end
      default: expect_word(STAT_OK, '0, 1'b0, 1'b1);
    endcase
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      stored_vals.delete();
      expected_words.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: status %0d, count %0d",
                 out_data_i.status, out_data_i.count);
          fail_count_o++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", VALUE_W'(want.status), VALUE_W'(out_data_i.status));
          check_field("entry_value", want.entry_value, out_data_i.entry_value);
          check_field("entry_valid", VALUE_W'(want.entry_valid),
                      VALUE_W'(out_data_i.entry_valid));
          check_field("last", VALUE_W'(want.last), VALUE_W'(out_data_i.last));
          check_field("count", VALUE_W'(want.count), VALUE_W'(out_data_i.count));
        end
      end
      if (in_valid_i && in_ready_i) apply_word(in_data_i);
      pending_o = expected_words.size();
    end
  end

endmodule

// ----- bench/sorted_list_table_engine_tb.sv -----
module sorted_list_table_engine_tb;
  import slte_pkg::*;

  localparam int unsigned DEPTH           = 16;
  localparam int unsigned MAX_GAP         = 6;
  localparam int unsigned RAND_ITEMS      = 100;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_ready = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_data;
  int        fail_count;
  int        pending;

  int unsigned               max_gap      = MAX_GAP;
  bit                        hold_off_req = 1'b0;
  logic signed [VALUE_W-1:0] inserted_vals[$];

  sorted_list_table_engine #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  sorted_table_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("sorted_list_table_engine regression: fail");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = hold_off_req ? HOLD_OFF_CYCLES : $urandom_range(0, max_gap);
      hold_off_req = 1'b0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1: v = $signed($urandom_range(0, 8)) - 4;
      2: v = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
      default: begin
        if (inserted_vals.size() > 0)
          v = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
        else
          v = $urandom();
      end
    endcase
    return v;
  endfunction

  task automatic push_word(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] value);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {kind, value};
    if (kind == KIND_INSERT) inserted_vals.push_back(value);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic fill_table();
    push_word(KIND_CLEAR, $urandom());
    repeat (DEPTH + 1) push_word(KIND_INSERT, pick_value());
    push_word(KIND_DUMP, $urandom());
  endtask

  task automatic mixed_op();
    int unsigned               r;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    r     = $urandom_range(0, 99);
    value = pick_value();
    if (r < 40) begin
      kind = KIND_INSERT;
    end else if (r < 78) begin
      kind = (r < 60) ? KIND_SEARCH : KIND_DELETE;
      if (inserted_vals.size() > 0 && $urandom_range(0, 9) < 7)
        value = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
    end else if (r < 88) begin
      kind = KIND_DUMP;
    end else if (r < 94) begin
      kind = KIND_CLEAR;
    end else begin
      kind = KIND_W'($urandom_range(int'(KIND_DUMP) + 1, 2**KIND_W - 1));
    end
    push_word(kind, value);
  endtask

  initial begin
    int unsigned rand_items;
    bit          hold_done;
    bit          pause_done;
    rand_items = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);

    push_word(KIND_SEARCH, '0);
    push_word(KIND_DELETE, '0);
    push_word(KIND_CLEAR, '0);
    push_word(KIND_DUMP, '0);
    push_word(KIND_INSERT, VALUE_MAX);
    push_word(KIND_INSERT, VALUE_MIN);
    push_word(KIND_INSERT, '0);
    push_word(KIND_INSERT, '0);
    push_word(KIND_INSERT, -1);
    push_word(KIND_SEARCH, '0);
    push_word(KIND_SEARCH, 7);
    push_word(KIND_DELETE, '0);
    push_word(KIND_DELETE, 7);
    push_word(KIND_SEARCH, VALUE_MIN);
    for (int k = int'(KIND_DUMP) + 1; k < 2**KIND_W; k++)
      push_word(KIND_W'(k), $urandom());
    push_word(KIND_DUMP, '1);

    while (rand_items < RAND_ITEMS) begin
      if (rand_items == 0 || (!hold_done && rand_items >= 40) || $urandom_range(0, 9) == 0) begin
        if (!hold_done && rand_items >= 40) begin
          hold_done    = 1'b1;
          max_gap      = 0;
          hold_off_req = 1'b1;
        end
        fill_table();
        max_gap    = MAX_GAP;
        rand_items += DEPTH + 3;
      end else begin
        mixed_op();
        rand_items++;
      end
      if (!pause_done && rand_items >= 70) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("sorted_list_table_engine regression: pass");
    end else begin
      $display("sorted_list_table_engine regression: fail");
    end
    $finish;
  end

endmodule
